// ----- design/laser_plotter_command_controller_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LASER_PLOTTER_COMMAND_CONTROLLER_UNIT_MACROS_SVH
`define LASER_PLOTTER_COMMAND_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpc check failed");

`endif

// ----- design/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// Types, command codes and constants of the laser plotter command controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam logic [7:0] JOG_COUNT        = 8'd160;
  localparam logic [7:0] PULSE_UNIT_TICKS = 8'd10;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] RPL_OK         = 8'h00;
  localparam logic [7:0] RPL_ID         = 8'h02;
  localparam logic [7:0] RPL_ABORT      = 8'h0C;
  localparam logic [7:0] ID_B2          = 8'd11;
  localparam logic [7:0] ID_B3          = 8'd2;
  localparam logic [7:0] STEP_PER_RST   = 8'd2;
  localparam logic [2:0] LASER_MASK_RST = 3'd5;

  localparam logic [7:0] CMD_STOP_A   = 8'h02;
  localparam logic [7:0] CMD_JOG      = 8'h03;
  localparam logic [7:0] CMD_STOP_B   = 8'h04;
  localparam logic [7:0] CMD_NOP      = 8'h05;
  localparam logic [7:0] CMD_IDENT    = 8'h09;
  localparam logic [7:0] CMD_MOVE     = 8'h21;
  localparam logic [7:0] CMD_PULSE    = 8'h22;
  localparam logic [7:0] CMD_PERIOD   = 8'h23;
  localparam logic [7:0] CMD_MASK     = 8'h25;
  localparam logic [7:0] CMD_FAN      = 8'h26;

  localparam logic [1:0] DIR_Y_POS = 2'd0;
  localparam logic [1:0] DIR_Y_NEG = 2'd1;
  localparam logic [1:0] DIR_X_NEG = 2'd2;
  localparam logic [1:0] DIR_X_POS = 2'd3;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_MOVE  = 2'd1,
    OP_PULSE = 2'd2,
    OP_JOG   = 2'd3
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       button_pressed;
  } in_item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [7:0] motor_lines;
    logic       laser_gate;
    logic       boost_enable;
    logic       laser_ttl;
    logic       fan_on;
    logic       led_on;
    logic       busy_res;
  } out_item_t;

  // Line levels after one item, shared by every beat of its reply.
  typedef struct packed {
    logic [7:0] motor;
    logic [2:0] laser;
    logic       fan;
    logic       led;
    logic       busy;
  } lines_t;

  // Everything the serializer needs to emit the beats of one item.
  typedef struct packed {
    logic       rep;
    logic [7:0] code;
    logic [7:0] b2;
    logic [7:0] b3;
    lines_t     lines;
  } pkt_t;

  // Full-step two-phase coil pattern.
  function automatic logic [3:0] coil_nibble(logic [1:0] ph);
    logic [3:0] r;
    case (ph)
      2'd0:    r = 4'hA;
      2'd1:    r = 4'h9;
      2'd2:    r = 4'h5;
      default: r = 4'h6;
    endcase
    return r;
  endfunction

endpackage

// ----- design/lpc_core.sv -----
// ----------------------------------------------------------------------------
// lpc_core
// Framer, command decoder and motion/pulse sequencer; one item per transfer.
// ----------------------------------------------------------------------------
module lpc_core import lpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  in_item_t item_i,
  output pkt_t     pkt_o
);

  logic [1:0] fp_q, fp_d;
  logic [7:0] fb0_q, fb1_q;
  logic [7:0] period_q, period_d;
  logic [2:0] mask_q, mask_d;
  logic [1:0] xph_q, xph_d, yph_q, yph_d;
  logic [7:0] motor_q, motor_d;
  logic [2:0] laser_q, laser_d;
  logic       fan_q, fan_d, led_q, led_d;
  op_e        op_q, op_d;
  logic [1:0] dir_q, dir_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] tcd_q, tcd_d;

  logic       adv, fin, abort, rep;
  logic [7:0] code, b2, b3, arg;

  assign arg = fb1_q;

  always_comb begin
    fp_d = fp_q; period_d = period_q; mask_d = mask_q;
    xph_d = xph_q; yph_d = yph_q; motor_d = motor_q; laser_d = laser_q;
    fan_d = fan_q; led_d = led_q; op_d = op_q; dir_d = dir_q;
    rem_d = rem_q; tcd_d = tcd_q;
    adv = 1'b0; fin = 1'b0; abort = 1'b0;
    rep = 1'b0; code = RPL_OK; b2 = 8'd0; b3 = 8'd0;

    if (item_i.kind) begin
      if (op_q != OP_IDLE) begin
        if (tcd_q <= 8'd1) begin
          tcd_d = 8'd0;
          adv   = 1'b1;
        end else begin
          tcd_d = tcd_q - 8'd1;
        end
      end
    end else if (op_q == OP_IDLE) begin
      if (fp_q == 2'd0) begin
        if (item_i.rx_byte == SYNC_BYTE) fp_d = 2'd1;
      end else if (fp_q != 2'd3) begin
        fp_d = fp_q + 2'd1;
      end else begin
        fp_d = 2'd0;
        // third payload byte is the one arriving now
        case (fb0_q)
          CMD_IDENT: begin
            rep = 1'b1; code = RPL_ID; b2 = ID_B2; b3 = ID_B3;
          end
          CMD_JOG: begin
            if (arg < 8'd1 || arg > 8'd4) begin
              rep = 1'b1;
            end else begin
              led_d = 1'b1;
              op_d  = OP_JOG;
              dir_d = 2'(arg - 8'd1);
              rem_d = JOG_COUNT;
              adv   = 1'b1;
            end
          end
          CMD_STOP_A, CMD_STOP_B: begin
            laser_d = 3'd0; fan_d = 1'b0; motor_d = 8'd0; rep = 1'b1;
          end
          CMD_NOP: rep = 1'b1;
          CMD_MOVE: begin
            led_d = 1'b1;
            if (arg[2]) begin
              fan_d   = 1'b1;
              laser_d = laser_q | mask_q;
            end
            op_d  = OP_MOVE;
            dir_d = arg[1:0];
            rem_d = item_i.rx_byte;
            adv   = 1'b1;
          end
          CMD_PULSE: begin
            led_d   = 1'b1;
            fan_d   = 1'b1;
            laser_d = laser_q | mask_q;
            op_d    = OP_PULSE;
            rem_d   = arg;
            adv     = 1'b1;
          end
          CMD_PERIOD: begin
            if (arg != 8'd0) period_d = arg;
            rep = 1'b1; b2 = period_d;
          end
          CMD_MASK: begin
            mask_d = arg[2:0];
            rep = 1'b1; b2 = {5'd0, arg[2:0]};
          end
          CMD_FAN: begin
            fan_d = (arg != 8'd0);
            rep = 1'b1; b2 = {7'd0, fan_d};
          end
          default: ;
        endcase
      end
    end

    // iteration boundary: end, abort or start the next step / pulse unit
    if (adv) begin
      if (rem_d == 8'd0) begin
        fin = 1'b1;
      end else if (item_i.button_pressed) begin
        fin = 1'b1; abort = 1'b1;
      end else begin
        if (op_d == OP_PULSE) begin
          tcd_d = PULSE_UNIT_TICKS;
        end else begin
          case (dir_d)
            DIR_Y_POS: yph_d = yph_q + 2'd1;
            DIR_Y_NEG: yph_d = yph_q - 2'd1;
            DIR_X_NEG: xph_d = xph_q - 2'd1;
            default:   xph_d = xph_q + 2'd1;
          endcase
          if (!dir_d[1]) motor_d[7:4] = coil_nibble(yph_d);
          else           motor_d[3:0] = coil_nibble(xph_d);
          tcd_d = period_q;
        end
        rem_d = rem_d - 8'd1;
      end
    end

    if (fin) begin
      rep = 1'b1;
      case (op_d)
        OP_MOVE: begin
          laser_d = 3'd0;
          if (abort) motor_d = 8'd0;
          code = abort ? RPL_ABORT : RPL_OK;
        end
        OP_PULSE: begin
          laser_d = 3'd0;
          code = abort ? RPL_ABORT : RPL_OK;
        end
        default: motor_d = 8'd0;
      endcase
      op_d = OP_IDLE; rem_d = 8'd0; tcd_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= 2'd0; period_q <= STEP_PER_RST; mask_q <= LASER_MASK_RST;
      xph_q <= 2'd0; yph_q <= 2'd0; motor_q <= 8'd0; laser_q <= 3'd0;
      fan_q <= 1'b0; led_q <= 1'b0; op_q <= OP_IDLE; dir_q <= 2'd0;
      rem_q <= 8'd0; tcd_q <= 8'd0;
    end else if (load_i) begin
      fp_q <= fp_d; period_q <= period_d; mask_q <= mask_d;
      xph_q <= xph_d; yph_q <= yph_d; motor_q <= motor_d; laser_q <= laser_d;
      fan_q <= fan_d; led_q <= led_d; op_q <= op_d; dir_q <= dir_d;
      rem_q <= rem_d; tcd_q <= tcd_d;
    end
  end

  // frame bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (load_i && !item_i.kind && op_q == OP_IDLE) begin
      if (fp_q == 2'd1) fb0_q <= item_i.rx_byte;
      if (fp_q == 2'd2) fb1_q <= item_i.rx_byte;
    end
  end

  assign pkt_o.rep         = rep;
  assign pkt_o.code        = code;
  assign pkt_o.b2          = b2;
  assign pkt_o.b3          = b3;
  assign pkt_o.lines.motor = motor_d;
  assign pkt_o.lines.laser = laser_d;
  assign pkt_o.lines.fan   = fan_d;
  assign pkt_o.lines.led   = led_d;
  assign pkt_o.lines.busy  = (op_d != OP_IDLE);

endmodule

// ----- design/lpc_serializer.sv -----
// ----------------------------------------------------------------------------
// lpc_serializer
// Holds one item's result and emits it as one beat or as a 4-byte reply.
// ----------------------------------------------------------------------------
module lpc_serializer import lpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  pkt_t      pkt_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  pkt_t       pkt_q;
  logic       full_q, full_d;
  logic [1:0] beat_q, beat_d;
  logic       last;
  logic [7:0] byte_sel;

  assign last = !pkt_q.rep || (beat_q == 2'd3);

  always_comb begin
    case (beat_q)
      2'd0:    byte_sel = SYNC_BYTE;
      2'd1:    byte_sel = pkt_q.code;
      2'd2:    byte_sel = pkt_q.b2;
      default: byte_sel = pkt_q.b3;
    endcase
  end

  // a new result may enter as the last beat leaves
  assign free_o = !full_q || (out_ready_i && last);

  always_comb begin
    full_d = full_q;
    beat_d = beat_q;
    if (full_q && out_ready_i) begin
      if (last) begin
        full_d = 1'b0;
        beat_d = 2'd0;
      end else begin
        beat_d = beat_q + 2'd1;
      end
    end
    if (load_i) begin
      full_d = 1'b1;
      beat_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      beat_q <= 2'd0;
    end else begin
      full_q <= full_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) pkt_q <= pkt_i;
  end

  assign out_valid_o               = full_q;
  assign out_data_o.reply_valid    = pkt_q.rep;
  assign out_data_o.reply_byte     = pkt_q.rep ? byte_sel : 8'd0;
  assign out_data_o.reply_last     = last;
  assign out_data_o.motor_lines    = pkt_q.lines.motor;
  assign out_data_o.laser_gate     = pkt_q.lines.laser[0];
  assign out_data_o.boost_enable   = pkt_q.lines.laser[1];
  assign out_data_o.laser_ttl      = pkt_q.lines.laser[2];
  assign out_data_o.fan_on         = pkt_q.lines.fan;
  assign out_data_o.led_on         = pkt_q.lines.led;
  assign out_data_o.busy_res       = pkt_q.lines.busy;

endmodule

// ----- design/laser_plotter_command_controller_unit.sv -----
// ----------------------------------------------------------------------------
// laser_plotter_command_controller_unit
// Serial command controller for a two-axis stepper laser plotter.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i): one item per transfer, a
// received serial byte or a 1 ms tick, plus the abort button level.
// Output channel (out_valid_o/out_ready_i/out_data_o): per input item either
// one beat with reply_valid low, or four reply beats FF code b2 b3 with
// reply_last on the fourth. Line fields show the state after the item.
// The first beat is valid in the cycle after the input transfer.
// Throughput: one item per cycle while out_ready_i is high and each item
// yields one beat; a reply occupies the output register for four beats. The
// single result register between decoder and output port sets this figure.
// The next item is taken in the same cycle the last beat is transferred.
// Output stall: in_ready_o drops while a result is held and not yet fully
// transferred; held beats stay stable.
// Reset: framer hunting for 0xFF, idle, motors coasting, laser, fan and LED
// off, step period 2, laser mask 5.
// ----------------------------------------------------------------------------
module laser_plotter_command_controller_unit import lpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic load;
  pkt_t pkt;

  assign load = in_valid_i && in_ready_o;

  lpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .item_i (in_data_i),
    .pkt_o  (pkt)
  );

  lpc_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .pkt_i       (pkt),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/lpc_checker.sv -----
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the laser plotter command controller.
// ----------------------------------------------------------------------------
`include "laser_plotter_command_controller_unit_macros.svh"

module lpc_checker import lpc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  `LPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))

  // a reply is never cut short
  `LPC_ASSERT_NEXT(a_reply_cont, clk_i, rst_ni,
                   out_valid_o && out_ready_i && !out_data_o.reply_last,
                   out_valid_o && out_data_o.reply_valid)

  `LPC_ASSERT_NOW(a_plain_beat, clk_i, rst_ni, out_valid_o && !out_data_o.reply_valid,
                  out_data_o.reply_last && out_data_o.reply_byte == 8'd0)

  // laser lines only burn during a running command
  `LPC_ASSERT_NOW(a_laser_idle, clk_i, rst_ni, out_valid_o && !out_data_o.busy_res,
                  !out_data_o.laser_gate && !out_data_o.boost_enable &&
                  !out_data_o.laser_ttl)

  `LPC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o)

endmodule

bind laser_plotter_command_controller_unit lpc_checker u_lpc_checker (.*);

// ----- sim/laser_plotter_command_controller_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// laser_plotter_command_controller_unit_tb
// Self-checking bench: feeds serial bytes and millisecond ticks through the
// input channel, predicts every output beat with a cycle-free model of the
// framer, command decoder, stepper and laser logic, and compares each beat
// field by field. A short table of directed frames runs first, followed by
// random framed commands, broken frames, stray bytes and tick runs with
// random button aborts. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module laser_plotter_command_controller_unit_tb;
  import lpc_pkg::*;

  localparam logic        KIND_BYTE     = 1'b0;
  localparam logic        KIND_TICK     = 1'b1;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_ITEMS  = 280;
  localparam int          MAX_RUN_TICKS = 600;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          PRINT_LIMIT   = 40;
  localparam int          N_DIRECTED    = 26;

  localparam logic [3:0] COIL_PAT [4] = '{4'hA, 4'h9, 4'h5, 4'h6};

  // Directed row; when has_reply is set the reply bytes are typed in here.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       btn;
    logic       has_reply;
    logic [7:0] code;
    logic [7:0] b2;
    logic [7:0] b3;
  } row_t;

  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{KIND_TICK, 8'h00,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},  // tick while idle
    '{KIND_BYTE, 8'h00,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},  // stray byte, no sync
    '{KIND_BYTE, SYNC_BYTE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_IDENT,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h00,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'hFF,      1'b0, 1'b1, RPL_ID, 8'd11, 8'd2},
    '{KIND_BYTE, SYNC_BYTE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_PERIOD, 1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h00,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},  // zero period kept
    '{KIND_BYTE, 8'hFF,      1'b0, 1'b1, RPL_OK, 8'd2,  8'd0},
    '{KIND_BYTE, SYNC_BYTE,  1'b1, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_MASK,   1'b1, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'hFF,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h00,      1'b1, 1'b1, RPL_OK, 8'd7,  8'd0},
    '{KIND_BYTE, SYNC_BYTE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_FAN,    1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h80,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h00,      1'b0, 1'b1, RPL_OK, 8'd1,  8'd0},
    '{KIND_BYTE, SYNC_BYTE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_PULSE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h00,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},  // zero pulse count
    '{KIND_BYTE, 8'h55,      1'b1, 1'b1, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, SYNC_BYTE,  1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, CMD_JOG,    1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},
    '{KIND_BYTE, 8'h05,      1'b0, 1'b0, RPL_OK, 8'd0,  8'd0},  // jog direction out of range
    '{KIND_BYTE, 8'hAA,      1'b0, 1'b1, RPL_OK, 8'd0,  8'd0}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  laser_plotter_command_controller_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  // Controller state as seen by the predictor.
  logic [1:0] frm_pos;
  logic [7:0] frm_buf [3];
  logic [7:0] per_reg;
  logic [2:0] mask_reg;
  logic [1:0] xph, yph;
  logic [7:0] coils;
  logic [2:0] beam;
  logic       fan_st, led_st;
  op_e        cur_op;
  logic [1:0] run_dir;
  logic [7:0] steps_left, tick_left;
  logic       rep_on;
  logic [7:0] rep_code, rep_b2, rep_b3;

  out_item_t  pend [4];
  int         pend_n;
  out_item_t  beats_q [$];

  int          errors = 0;
  int          beat_no = 0;
  int          items_sent = 0;
  int unsigned cycles = 0;
  logic        quiet = 1'b0;

  task automatic ctrl_reset();
    frm_pos    = '0;
    frm_buf    = '{8'h00, 8'h00, 8'h00};
    per_reg    = STEP_PER_RST;
    mask_reg   = LASER_MASK_RST;
    xph        = '0;
    yph        = '0;
    coils      = '0;
    beam       = '0;
    fan_st     = 1'b0;
    led_st     = 1'b0;
    cur_op     = OP_IDLE;
    run_dir    = '0;
    steps_left = '0;
    tick_left  = '0;
  endtask

  task automatic post(input logic [7:0] code, input logic [7:0] b2, input logic [7:0] b3);
    rep_on   = 1'b1;
    rep_code = code;
    rep_b2   = b2;
    rep_b3   = b3;
  endtask

  task automatic beam_on();
    fan_st = 1'b1;
    beam   = beam | mask_reg;
  endtask

  task automatic step_motor(input logic [1:0] d);
    case (d)
      DIR_Y_POS: yph = yph + 2'd1;
      DIR_Y_NEG: yph = yph - 2'd1;
      DIR_X_NEG: xph = xph - 2'd1;
      default:   xph = xph + 2'd1;
    endcase
    if (d == DIR_Y_POS || d == DIR_Y_NEG) coils[7:4] = COIL_PAT[yph];
    else coils[3:0] = COIL_PAT[xph];
  endtask

  task automatic end_op(input logic aborted);
    case (cur_op)
      OP_MOVE: begin
        beam = '0;
        if (aborted) coils = '0;
        post(aborted ? RPL_ABORT : RPL_OK, 8'd0, 8'd0);
      end
      OP_PULSE: begin
        beam = '0;
        post(aborted ? RPL_ABORT : RPL_OK, 8'd0, 8'd0);
      end
      default: begin
        // jog always reports OK, abort or not
        coils = '0;
        post(RPL_OK, 8'd0, 8'd0);
      end
    endcase
    cur_op     = OP_IDLE;
    steps_left = '0;
    tick_left  = '0;
  endtask

  // Step or pulse-unit boundary: button sampled only while iterations remain.
  task automatic next_iter(input logic btn);
    if (steps_left == 8'd0) end_op(1'b0);
    else if (btn) end_op(1'b1);
    else begin
      if (cur_op == OP_PULSE) tick_left = PULSE_UNIT_TICKS;
      else begin
        step_motor(run_dir);
        tick_left = per_reg;
      end
      steps_left = steps_left - 8'd1;
    end
  endtask

  task automatic run_frame(input logic btn);
    logic [7:0] a;
    a = frm_buf[1];
    case (frm_buf[0])
      CMD_IDENT: post(RPL_ID, ID_B2, ID_B3);
      CMD_JOG: begin
        if (a < 8'd1 || a > 8'd4) post(RPL_OK, 8'd0, 8'd0);
        else begin
          led_st     = 1'b1;
          cur_op     = OP_JOG;
          run_dir    = 2'(a - 8'd1);
          steps_left = JOG_COUNT;
          next_iter(btn);
        end
      end
      CMD_STOP_A, CMD_STOP_B: begin
        beam   = '0;
        fan_st = 1'b0;
        coils  = '0;
        post(RPL_OK, 8'd0, 8'd0);
      end
      CMD_NOP: post(RPL_OK, 8'd0, 8'd0);
      CMD_MOVE: begin
        led_st = 1'b1;
        if (a[2]) beam_on();
        cur_op     = OP_MOVE;
        run_dir    = a[1:0];
        steps_left = frm_buf[2];
        next_iter(btn);
      end
      CMD_PULSE: begin
        led_st = 1'b1;
        beam_on();
        cur_op     = OP_PULSE;
        steps_left = a;
        next_iter(btn);
      end
      CMD_PERIOD: begin
        if (a != 8'd0) per_reg = a;
        post(RPL_OK, per_reg, 8'd0);
      end
      CMD_MASK: begin
        mask_reg = a[2:0];
        post(RPL_OK, {5'd0, mask_reg}, 8'd0);
      end
      CMD_FAN: begin
        fan_st = (a != 8'd0);
        post(RPL_OK, {7'd0, fan_st}, 8'd0);
      end
      default: ;
    endcase
  endtask

  // Turns pend[0]'s line levels into the four beats of a reply.
  task automatic load_reply(input logic [7:0] code, input logic [7:0] b2,
                            input logic [7:0] b3);
    out_item_t  base;
    logic [7:0] bytes [4];
    base  = pend[0];
    bytes = '{SYNC_BYTE, code, b2, b3};
    for (int k = 0; k < 4; k++) begin
      pend[k]             = base;
      pend[k].reply_valid = 1'b1;
      pend[k].reply_byte  = bytes[k];
      pend[k].reply_last  = (k == 3);
    end
    pend_n = 4;
  endtask

  task automatic apply_item(input in_item_t it);
    rep_on = 1'b0;
    if (it.kind == KIND_TICK) begin
      if (cur_op != OP_IDLE) begin
        if (tick_left <= 8'd1) begin
          tick_left = '0;
          next_iter(it.button_pressed);
        end else tick_left = tick_left - 8'd1;
      end
    end else if (cur_op == OP_IDLE) begin
      if (frm_pos == 2'd0) begin
        if (it.rx_byte == SYNC_BYTE) frm_pos = 2'd1;
      end else begin
        frm_buf[frm_pos - 2'd1] = it.rx_byte;
        if (frm_pos == 2'd3) begin
          frm_pos = 2'd0;
          run_frame(it.button_pressed);
        end else frm_pos = frm_pos + 2'd1;
      end
    end
    pend[0] = '{reply_valid: 1'b0, reply_byte: 8'd0, reply_last: 1'b1,
                motor_lines: coils, laser_gate: beam[0], boost_enable: beam[1],
                laser_ttl: beam[2], fan_on: fan_st, led_on: led_st,
                busy_res: (cur_op != OP_IDLE)};
    pend_n = 1;
    if (rep_on) load_reply(rep_code, rep_b2, rep_b3);
  endtask

  task automatic push_pending();
    for (int k = 0; k < pend_n; k++) beats_q.push_back(pend[k]);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one item and returns at the edge of its transfer.
  task automatic drive_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_item(input logic kind, input logic [7:0] data, input logic btn);
    in_item_t it;
    logic     ignored;
    it      = '{kind: kind, rx_byte: data, button_pressed: btn};
    ignored = (kind == KIND_BYTE) && (cur_op != OP_IDLE);
    drive_item(it);
    apply_item(it);
    push_pending();
    if (!ignored) items_sent++;
  endtask

  // Ticks until the running operation ends; some runs are aborted by button.
  task automatic run_to_idle();
    int ticks;
    int abort_at;
    ticks = 0;
    if (cur_op == OP_JOG)
      abort_at = ($urandom_range(0, 9) == 0) ? MAX_RUN_TICKS : $urandom_range(0, 40);
    else
      abort_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : MAX_RUN_TICKS;
    while (cur_op != OP_IDLE) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_BYTE, 8'($urandom), 1'($urandom));  // dropped while busy
      end else begin
        send_item(KIND_TICK, 8'($urandom),
                  (ticks >= abort_at) || ($urandom_range(0, 19) == 0));
        ticks++;
      end
    end
  endtask

  // Back to idle with the framer hunting for sync.
  task automatic realign();
    while (cur_op != OP_IDLE || frm_pos != 2'd0) begin
      if (cur_op != OP_IDLE) run_to_idle();
      else send_item(KIND_BYTE, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_command();
    logic [7:0] code, a, b;
    int         r, s;
    r = $urandom_range(0, 99);
    a = 8'($urandom);
    b = 8'($urandom);
    if (r < 10) code = CMD_IDENT;
    else if (r < 20) begin
      code = CMD_JOG;
      if ($urandom_range(0, 4) != 0) a = 8'($urandom_range(1, 4));
      else if ($urandom_range(0, 1) == 0) a = 8'($urandom_range(0, 5));
    end else if (r < 28) code = ($urandom_range(0, 1) == 0) ? CMD_STOP_A : CMD_STOP_B;
    else if (r < 32) code = CMD_NOP;
    else if (r < 52) begin
      code = CMD_MOVE;
      if ($urandom_range(0, 9) != 0) b = 8'($urandom_range(0, 5));
    end else if (r < 64) begin
      code = CMD_PULSE;
      if ($urandom_range(0, 9) != 0) a = 8'($urandom_range(0, 3));
    end else if (r < 74) begin
      code = CMD_PERIOD;
      s = $urandom_range(0, 9);
      if (s < 7) a = 8'($urandom_range(1, 3));
      else if (s < 8) a = 8'd0;
      else if (s < 9) a = 8'hFF;
    end else if (r < 82) code = CMD_MASK;
    else if (r < 92) begin
      code = CMD_FAN;
      if ($urandom_range(0, 2) == 0) a = 8'd0;
    end else code = 8'($urandom);  // mostly undefined codes
    send_item(KIND_BYTE, SYNC_BYTE, 1'($urandom));
    send_item(KIND_BYTE, code, 1'($urandom));
    send_item(KIND_BYTE, a, 1'($urandom));
    send_item(KIND_BYTE, b, $urandom_range(0, 7) == 0);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned seen);
    if (errors < PRINT_LIMIT)
      $display("[%0t] beat %0d %s: expected %0h, got %0h", $time, beat_no, what, want, seen);
    errors++;
  endtask

  task automatic check_beat(input out_item_t got, input out_item_t want);
    if (got.reply_valid !== want.reply_valid)
      report_mismatch("reply_valid", want.reply_valid, got.reply_valid);
    if (got.reply_byte !== want.reply_byte)
      report_mismatch("reply_byte", want.reply_byte, got.reply_byte);
    if (got.reply_last !== want.reply_last)
      report_mismatch("reply_last", want.reply_last, got.reply_last);
    if (got.motor_lines !== want.motor_lines)
      report_mismatch("motor_lines", want.motor_lines, got.motor_lines);
    if (got.laser_gate !== want.laser_gate)
      report_mismatch("laser_gate", want.laser_gate, got.laser_gate);
    if (got.boost_enable !== want.boost_enable)
      report_mismatch("boost_enable", want.boost_enable, got.boost_enable);
    if (got.laser_ttl !== want.laser_ttl)
      report_mismatch("laser_ttl", want.laser_ttl, got.laser_ttl);
    if (got.fan_on !== want.fan_on)
      report_mismatch("fan_on", want.fan_on, got.fan_on);
    if (got.led_on !== want.led_on)
      report_mismatch("led_on", want.led_on, got.led_on);
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", want.busy_res, got.busy_res);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (beats_q.size() == 0) report_mismatch("unexpected beat", 0, out_data);
      else check_beat(out_data, beats_q.pop_front());
      beat_no++;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    logic     paused;
    paused   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    ctrl_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      it = '{kind: DIRECTED[i].kind, rx_byte: DIRECTED[i].data,
             button_pressed: DIRECTED[i].btn};
      drive_item(it);
      apply_item(it);
      if (DIRECTED[i].has_reply)
        load_reply(DIRECTED[i].code, DIRECTED[i].b2, DIRECTED[i].b3);
      push_pending();
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) quiet = !quiet;
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        // hold off the sender until the output side has caught up
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom), 1'($urandom));
        1: begin
          // truncated frame, completed by whatever follows
          send_item(KIND_BYTE, SYNC_BYTE, 1'b0);
          send_item(KIND_BYTE, 8'($urandom), 1'b0);
        end
        default: send_command();
      endcase
      realign();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
